// ----- hdl/amde_pkg.sv -----
// Shared constants for the adjacency matrix degree engine.
package amde_pkg;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_WEIGHT_BITS  = 16;

  localparam int OP_W    = 3;
  localparam int VTX_W   = 6;
  localparam int WIN_W   = 16;
  localparam int VC_W    = 7;
  localparam int EW_W    = 16;
  localparam int HALF_W  = 14;
  localparam int TOTAL_W = 13;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  localparam logic [VC_W-1:0]   VC_RESET = 7'd64;
  localparam logic [HALF_W-1:0] HALF_MAX = 14'h3FFF;

  localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
  localparam logic [OP_W-1:0] OP_WEIGHT  = 3'd2;
  localparam logic [OP_W-1:0] OP_INDEG   = 3'd3;
  localparam logic [OP_W-1:0] OP_OUTDEG  = 3'd4;
  localparam logic [OP_W-1:0] OP_SUM_IN  = 3'd5;
  localparam logic [OP_W-1:0] OP_SUM_OUT = 3'd6;

endpackage

// ----- hdl/amde_store.sv -----
// Weight matrix memory with a clearing sweep after reset.
module amde_store import amde_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS,
  localparam int AW = 2 * $clog2(MAX_VERTICES)
) (
  input  logic                   clk,
  input  logic                   rst,
  output logic                   clearing,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [WEIGHT_BITS-1:0] wdata,
  input  logic [AW-1:0]          raddr,
  output logic [WEIGHT_BITS-1:0] rdata
);

  localparam int DEPTH = 1 << AW;

  logic [WEIGHT_BITS-1:0] mem [DEPTH];
  logic [AW-1:0]          clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/adjacency_matrix_degree_engine.sv -----
// Top level of the adjacency matrix degree engine: control sequencer and ports.
//
// Input transactions arrive on s_axis_*, one operation each; every transaction
// yields exactly one result transaction on m_axis_*. The vertex count register
// is written through cfg_wdata when cfg_we is high; the user must write it only
// while the engine is idle, as the block itself does not enforce this.
// One operation is processed at a time; the weight matrix sits in a single
// memory with one read and one write port, and every operation works through
// reads of that port (n is the live vertex count). The next input is taken
// once the result has been loaded into the output register.
//   add, remove, weight:     a read, then a write for an add or remove that changes the entry.
//   in- and out-degree:      one row or column scan of n entries.
//   neighbour degree sums:   one read per vertex checked, plus a scan of n
//                            entries for each out-neighbour found.
// Out-of-range vertices and the unused operation code go straight to the result.
// After reset the matrix is cleared by a sweep of one entry per cycle over all
// 4**ceil(log2(MAX_VERTICES)) entries (4096 at the default size); s_axis_tready
// stays low until it is done. The result waits in an output register while the
// receiver stalls; the next input is taken meanwhile, and its result is held
// back until the register is free.
module adjacency_matrix_degree_engine import amde_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [VC_W-1:0]        cfg_wdata,      // vertex_count
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // operation[2:0], vertex[8:3], other_vertex[14:9], weight[30:15], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // edge_weight[15:0], half_units[29:16], edge_total[42:30], status[43], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int AW   = 2 * VW;
  localparam int NW   = $clog2(MAX_VERTICES + 1);
  localparam int CW   = (NW > VC_W) ? NW : VC_W;
  localparam int HW   = NW + 1;
  localparam int EC_W = $clog2(MAX_VERTICES * MAX_VERTICES + 1);

  localparam logic [3:0] ST_CLEAR     = 4'd0;
  localparam logic [3:0] ST_IDLE      = 4'd1;
  localparam logic [3:0] ST_EDGE_RD   = 4'd2;
  localparam logic [3:0] ST_EDGE_WR   = 4'd3;
  localparam logic [3:0] ST_SCAN      = 4'd4;
  localparam logic [3:0] ST_SCAN_WAIT = 4'd5;
  localparam logic [3:0] ST_DEG       = 4'd6;
  localparam logic [3:0] ST_OUTER_RD  = 4'd7;
  localparam logic [3:0] ST_OUTER_CHK = 4'd8;
  localparam logic [3:0] ST_RESULT    = 4'd9;

  logic [3:0]             state;
  logic [VC_W-1:0]        vertex_count;
  logic [CW-1:0]          live_n;
  logic [CW-1:0]          live_last;

  logic [OP_W-1:0]        in_op;
  logic [VTX_W-1:0]       in_vertex;
  logic [VTX_W-1:0]       in_other;
  logic [WIN_W-1:0]       in_weight;
  logic                   vtx_out;
  logic                   oth_out;

  logic [OP_W-1:0]        op;
  logic [VW-1:0]          vtx;
  logic [VW-1:0]          oth;
  logic [WEIGHT_BITS-1:0] wt;
  logic [VW-1:0]          outer_i;
  logic [VW-1:0]          scan_j;
  logic [VW-1:0]          line;
  logic [NW-1:0]          cnt;
  logic                   rd_vld;
  logic [HALF_W-1:0]      sum;
  logic [EC_W-1:0]        edge_count;
  logic [EW_W-1:0]        res_ew;
  logic [HALF_W-1:0]      res_half;
  logic                   res_status;

  logic                   incoming;
  logic                   is_sum;
  logic                   do_add;
  logic                   do_remove;
  logic [HW-1:0]          half_deg;
  logic [HALF_W:0]        sum_wide;
  logic [HALF_W-1:0]      sum_sat;

  logic                   clearing;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [WEIGHT_BITS-1:0] mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [WEIGHT_BITS-1:0] mem_rdata;

  amde_store #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .we       (mem_we),
    .waddr    (mem_waddr),
    .wdata    (mem_wdata),
    .raddr    (mem_raddr),
    .rdata    (mem_rdata)
  );

  assign in_op     = s_axis_tdata[2:0];
  assign in_vertex = s_axis_tdata[8:3];
  assign in_other  = s_axis_tdata[14:9];
  assign in_weight = s_axis_tdata[30:15];

  // A count above the matrix size behaves as the matrix size.
  assign live_n    = (CW'(vertex_count) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                             : CW'(vertex_count);
  assign live_last = live_n - 1'b1;
  assign vtx_out   = CW'(in_vertex) >= live_n;
  assign oth_out   = CW'(in_other) >= live_n;

  assign s_axis_tready = (state == ST_IDLE);

  assign incoming  = (op == OP_INDEG) || (op == OP_SUM_IN);
  assign is_sum    = (op == OP_SUM_IN) || (op == OP_SUM_OUT);
  assign do_add    = (op == OP_ADD) && (mem_rdata == '0) && (wt != '0);
  assign do_remove = (op == OP_REMOVE) && (mem_rdata != '0);

  // A vertex without edges in the scanned direction counts as one half.
  assign half_deg = (cnt == '0) ? HW'(1) : {cnt, 1'b0};
  assign sum_wide = {1'b0, sum} + (HALF_W + 1)'(half_deg);
  assign sum_sat  = sum_wide[HALF_W] ? HALF_MAX : sum_wide[HALF_W-1:0];

  assign mem_we    = (state == ST_EDGE_WR) && (do_add || do_remove);
  assign mem_waddr = {vtx, oth};
  assign mem_wdata = do_add ? wt : '0;

  always_comb begin
    case (state)
      ST_SCAN:     mem_raddr = incoming ? {scan_j, line} : {line, scan_j};
      ST_OUTER_RD: mem_raddr = {vtx, outer_i};
      default:     mem_raddr = {vtx, oth};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VC_RESET;
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      edge_count    <= '0;
      rd_vld        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      rd_vld <= (state == ST_SCAN);
      if (rd_vld && (mem_rdata != '0)) begin
        cnt <= cnt + 1'b1;
      end
      // The result state decides the valid flag on its own.
      if (m_axis_tvalid && m_axis_tready && (state != ST_RESULT)) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          if (!clearing) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op         <= in_op;
            vtx        <= VW'(in_vertex);
            oth        <= VW'(in_other);
            wt         <= WEIGHT_BITS'(in_weight);
            res_ew     <= '0;
            res_half   <= '0;
            res_status <= 1'b0;
            if (in_op inside {OP_ADD, OP_REMOVE, OP_WEIGHT}) begin
              if (vtx_out || oth_out) begin
                res_status <= 1'b1;
                state      <= ST_RESULT;
              end else begin
                state <= ST_EDGE_RD;
              end
            end else if (in_op inside {OP_INDEG, OP_OUTDEG}) begin
              if (vtx_out) begin
                res_status <= 1'b1;
                state      <= ST_RESULT;
              end else begin
                cnt    <= '0;
                scan_j <= '0;
                line   <= VW'(in_vertex);
                state  <= ST_SCAN;
              end
            end else if (in_op inside {OP_SUM_IN, OP_SUM_OUT}) begin
              if (vtx_out) begin
                res_status <= 1'b1;
                state      <= ST_RESULT;
              end else begin
                outer_i <= '0;
                sum     <= '0;
                state   <= ST_OUTER_RD;
              end
            end else begin
              state <= ST_RESULT;
            end
          end
        end

        ST_EDGE_RD: begin
          state <= ST_EDGE_WR;
        end

        ST_EDGE_WR: begin
          if (do_add) begin
            res_ew     <= EW_W'(wt);
            edge_count <= edge_count + 1'b1;
          end else if (do_remove) begin
            res_ew     <= '0;
            edge_count <= edge_count - 1'b1;
          end else begin
            res_ew <= EW_W'(mem_rdata);
          end
          state <= ST_RESULT;
        end

        ST_SCAN: begin
          scan_j <= scan_j + 1'b1;
          if (CW'(scan_j) == live_last) begin
            state <= ST_SCAN_WAIT;
          end
        end

        // The last read of the scan is counted in this cycle.
        ST_SCAN_WAIT: begin
          state <= ST_DEG;
        end

        ST_DEG: begin
          if (is_sum) begin
            sum <= sum_sat;
            if (CW'(outer_i) == live_last) begin
              res_half <= sum_sat;
              state    <= ST_RESULT;
            end else begin
              outer_i <= outer_i + 1'b1;
              state   <= ST_OUTER_RD;
            end
          end else begin
            res_half <= HALF_W'(half_deg);
            state    <= ST_RESULT;
          end
        end

        ST_OUTER_RD: begin
          state <= ST_OUTER_CHK;
        end

        ST_OUTER_CHK: begin
          if (mem_rdata != '0) begin
            line   <= outer_i;
            scan_j <= '0;
            cnt    <= '0;
            state  <= ST_SCAN;
          end else if (CW'(outer_i) == live_last) begin
            res_half <= sum;
            state    <= ST_RESULT;
          end else begin
            outer_i <= outer_i + 1'b1;
            state   <= ST_OUTER_RD;
          end
        end

        ST_RESULT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {4'b0, res_status, TOTAL_W'(edge_count), res_half, res_ew};
            state         <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The edge count moves only when an add or remove is settled.
  a_count_only_on_edge_write: assert property (@(posedge clk) disable iff (rst)
    state != ST_EDGE_WR |=> $stable(edge_count))
    else $error("edge count changed outside an edge update");

  // A finished scan never counts more neighbours than live vertices.
  a_degree_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_DEG |-> CW'(cnt) <= live_n)
    else $error("degree count exceeds vertex count");

  // A new result is presented only from the result state.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == ST_RESULT)
    else $error("result presented outside the result state");

  // Only one operation is in progress: an accepted transaction closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an operation is in progress");

endmodule

// ----- tb/degree_engine_checker.sv -----
// Checker for the adjacency matrix degree engine: predicts every result and compares it.
module degree_engine_checker import amde_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [VC_W-1:0]        cfg_wdata,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output int unsigned            failures,
  output int unsigned            pending
);

  typedef struct packed {
    logic [EW_W-1:0]    edge_weight;
    logic [HALF_W-1:0]  half_units;
    logic [TOTAL_W-1:0] edge_total;
    logic               status;
  } engine_result_t;

  logic [WIN_W-1:0] weight_matrix [DEF_MAX_VERTICES][DEF_MAX_VERTICES];
  int unsigned      edge_tally;
  logic [VC_W-1:0]  vertex_limit;
  engine_result_t   expected_results [$];

  // A count above the matrix size behaves as the full matrix.
  function automatic int unsigned live_vertices();
    return (vertex_limit > DEF_MAX_VERTICES) ? DEF_MAX_VERTICES : int'(vertex_limit);
  endfunction

  // Degree times two, where a vertex with no edges counts as one half.
  function automatic int unsigned degree_halves(int unsigned vtx, int unsigned n,
                                                bit incoming);
    int unsigned links;
    links = 0;
    for (int i = 0; i < n; i++) begin
      if ((incoming ? weight_matrix[i][vtx] : weight_matrix[vtx][i]) != '0) links++;
    end
    return (links == 0) ? 1 : 2 * links;
  endfunction

  function automatic int unsigned neighbor_degree_sum(int unsigned vtx, int unsigned n,
                                                      bit incoming);
    int unsigned total;
    total = 0;
    for (int i = 0; i < n; i++) begin
      if (weight_matrix[vtx][i] != '0) total += degree_halves(i, n, incoming);
    end
    return total;
  endfunction

  // Applies one operation to the local copy of the graph and returns its result.
  function automatic engine_result_t apply_operation(logic [OP_W-1:0] op,
                                                     logic [VTX_W-1:0] src,
                                                     logic [VTX_W-1:0] dst,
                                                     logic [WIN_W-1:0] wt);
    engine_result_t res;
    int unsigned    n;
    int unsigned    half;
    n    = live_vertices();
    res  = '0;
    half = 0;
    case (op)
      OP_ADD, OP_REMOVE, OP_WEIGHT: begin
        if (src >= n || dst >= n) begin
          res.status = 1'b1;
        end else begin
          if (op == OP_ADD && weight_matrix[src][dst] == '0 && wt != '0) begin
            weight_matrix[src][dst] = wt;
            edge_tally++;
          end else if (op == OP_REMOVE && weight_matrix[src][dst] != '0) begin
            weight_matrix[src][dst] = '0;
            edge_tally--;
          end
          res.edge_weight = weight_matrix[src][dst];
        end
      end
      OP_INDEG, OP_OUTDEG, OP_SUM_IN, OP_SUM_OUT: begin
        if (src >= n) begin
          res.status = 1'b1;
        end else begin
          case (op)
            OP_INDEG:  half = degree_halves(src, n, 1'b1);
            OP_OUTDEG: half = degree_halves(src, n, 1'b0);
            OP_SUM_IN: half = neighbor_degree_sum(src, n, 1'b1);
            default:   half = neighbor_degree_sum(src, n, 1'b0);
          endcase
          res.half_units = (half > HALF_MAX) ? HALF_MAX : half[HALF_W-1:0];
        end
      end
      default: ;
    endcase
    res.edge_total = edge_tally[TOTAL_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    engine_result_t want;
    if (rst) begin
      for (int r = 0; r < DEF_MAX_VERTICES; r++) begin
        for (int c = 0; c < DEF_MAX_VERTICES; c++) weight_matrix[r][c] = '0;
      end
      edge_tally   = 0;
      vertex_limit = VC_RESET;
      expected_results.delete();
      failures = 0;
    end else begin
      if (cfg_we) vertex_limit = cfg_wdata;
      // The result side is handled first so that a result never meets its own input.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no operation outstanding: tdata %h", m_axis_tdata);
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("edge_weight", want.edge_weight, m_axis_tdata[EW_W-1:0]);
          check_field("half_units", want.half_units,
                      m_axis_tdata[EW_W+HALF_W-1:EW_W]);
          check_field("edge_total", want.edge_total,
                      m_axis_tdata[EW_W+HALF_W+TOTAL_W-1:EW_W+HALF_W]);
          check_field("status", want.status, m_axis_tdata[EW_W+HALF_W+TOTAL_W]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(apply_operation(
          s_axis_tdata[OP_W-1:0],
          s_axis_tdata[OP_W+VTX_W-1:OP_W],
          s_axis_tdata[OP_W+2*VTX_W-1:OP_W+VTX_W],
          s_axis_tdata[OP_W+2*VTX_W+WIN_W-1:OP_W+2*VTX_W]));
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the degree engine testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
  import amde_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [VC_W-1:0]        cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int unsigned failures;
  int unsigned pending;
  int          burst_left = 0;
  int          live_n = DEF_MAX_VERTICES;
  int          rx_mode = 0;
  int          rx_left = 0;
  int          phase_counts [16] = '{8, 3, 1, 16, 2, 64, 5, 0, 12, 127, 6, 32, 4, 100, 10, 7};

  adjacency_matrix_degree_engine dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  degree_engine_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .failures     (failures),
    .pending      (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver switches between always ready, light stalls and long stalls.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(50, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Sends one operation; the sender works in bursts with random gaps between them.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [VTX_W-1:0] src,
                           input logic [VTX_W-1:0] dst, input logic [WIN_W-1:0] wt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, wt, dst, src, op};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [VC_W-1:0] count);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    live_n = (count > DEF_MAX_VERTICES) ? DEF_MAX_VERTICES : int'(count);
  endtask

  // Mostly in-range operations that build up the graph, with some out-of-range noise.
  task automatic random_op(input int n);
    int               pick;
    logic [OP_W-1:0]  op;
    logic [VTX_W-1:0] src;
    logic [VTX_W-1:0] dst;
    logic [WIN_W-1:0] wt;
    pick = $urandom_range(0, 99);
    if (pick < 35)      op = OP_ADD;
    else if (pick < 50) op = OP_REMOVE;
    else if (pick < 58) op = OP_WEIGHT;
    else if (pick < 66) op = OP_INDEG;
    else if (pick < 74) op = OP_OUTDEG;
    else if (pick < 85) op = OP_SUM_IN;
    else if (pick < 96) op = OP_SUM_OUT;
    else                op = OP_UNUSED;
    if (n == 0 || $urandom_range(0, 9) == 0) begin
      src = VTX_W'($urandom_range(0, 63));
      dst = VTX_W'($urandom_range(0, 63));
    end else begin
      src = VTX_W'($urandom_range(0, n - 1));
      dst = VTX_W'($urandom_range(0, n - 1));
    end
    case ($urandom_range(0, 7))
      0:       wt = '0;
      1:       wt = WIN_W'($urandom_range(1, 3));
      default: wt = WIN_W'($urandom_range(0, 65535));
    endcase
    send_item(op, src, dst, wt);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Full-size graph after reset: corner slots, extreme weights and every operation.
    send_item(OP_ADD, 6'd0, 6'd0, 16'h0001);
    send_item(OP_ADD, 6'd63, 6'd63, 16'hFFFF);
    send_item(OP_ADD, 6'd0, 6'd63, 16'h8000);
    send_item(OP_ADD, 6'd0, 6'd1, 16'h0000);
    send_item(OP_ADD, 6'd0, 6'd0, 16'h1234);
    send_item(OP_WEIGHT, 6'd0, 6'd0, 16'h0000);
    send_item(OP_REMOVE, 6'd0, 6'd0, 16'h0000);
    send_item(OP_REMOVE, 6'd0, 6'd0, 16'hFFFF);
    send_item(OP_ADD, 6'd63, 6'd0, 16'hAAAA);
    send_item(OP_INDEG, 6'd63, 6'd0, 16'h0000);
    send_item(OP_OUTDEG, 6'd5, 6'd0, 16'h0000);
    send_item(OP_SUM_IN, 6'd0, 6'd0, 16'h0000);
    send_item(OP_SUM_OUT, 6'd63, 6'd0, 16'h0000);
    send_item(OP_SUM_IN, 6'd10, 6'd0, 16'h0000);
    send_item(OP_UNUSED, 6'd63, 6'd63, 16'h5555);

    // Shrunk count: out-of-range vertices, and edges beyond the count stay counted.
    write_vertex_count(7'd4);
    send_item(OP_ADD, 6'd5, 6'd1, 16'h0007);
    send_item(OP_ADD, 6'd1, 6'd63, 16'h0007);
    send_item(OP_INDEG, 6'd4, 6'd0, 16'h0000);
    send_item(OP_OUTDEG, 6'd0, 6'd0, 16'h0000);
    send_item(OP_ADD, 6'd1, 6'd2, 16'h0007);
    send_item(OP_SUM_IN, 6'd1, 6'd0, 16'h0000);

    // A zero count rejects every vertex; the largest count acts as the full matrix.
    write_vertex_count(7'd0);
    send_item(OP_WEIGHT, 6'd0, 6'd0, 16'h0000);
    send_item(OP_INDEG, 6'd0, 6'd0, 16'h0000);
    write_vertex_count(7'd127);
    send_item(OP_SUM_OUT, 6'd63, 6'd0, 16'h0000);
    send_item(OP_WEIGHT, 6'd63, 6'd63, 16'h0000);

    foreach (phase_counts[p]) begin
      write_vertex_count(phase_counts[p][VC_W-1:0]);
      repeat (25) begin
        if ($urandom_range(0, 39) == 0) drain_results();
        random_op(live_n);
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
